### sv/scic_pkg.sv
// shared types and constants for the scanline irq counter
package scic_pkg;

    typedef enum logic [1:0] {
        FN_CPU_WRITE = 2'd0,
        FN_CPU_READ  = 2'd1,
        FN_VID_READ  = 2'd2,
        FN_VID_WRITE = 2'd3
    } t_func;

    localparam logic [15:0] ADDR_TARGET    = 16'h5203;
    localparam logic [15:0] ADDR_STATUS    = 16'h5204;
    localparam logic [15:0] ADDR_PROD_LO   = 16'h5205;
    localparam logic [15:0] ADDR_PROD_HI   = 16'h5206;
    localparam logic [15:0] ATTR_BASE      = 16'h23C0;
    localparam logic [15:0] FOLD_MASK      = 16'h2FFF;
    localparam logic [15:0] FOLD_LIMIT     = 16'h3000;
    localparam logic [7:0]  FRAME_MASK     = 8'h18;
    localparam logic [7:0]  STAT_IN_FRAME  = 8'h40;
    localparam logic [7:0]  STAT_PENDING   = 8'h80;
    localparam logic [1:0]  REPEAT_MAX     = 2'd3;
    localparam logic [1:0]  REPEAT_FIRST   = 2'd1;
    localparam logic [2:0]  PPU_REG_LOW    = 3'd1;
    localparam logic [2:0]  PPU_WIN_HIGH   = 3'b001;

    typedef struct packed {
        t_func       func;
        logic [15:0] address;
        logic [7:0]  data;
        logic        rendering;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
    } t_result;

endpackage

### sv/scic_mult.sv
// 8x8 unsigned multiplier for the product read-back registers
module scic_mult (
    input  logic [7:0]  i_factor_a,
    input  logic [7:0]  i_factor_b,
    output logic [15:0] o_product
);

    assign o_product = {8'd0, i_factor_a} * {8'd0, i_factor_b};

endmodule

### sv/scic_state.sv
// mapper state registers and per-beat next-state and result logic
module scic_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  scic_pkg::t_item   i_item,
    output scic_pkg::t_result o_result
);

    logic [7:0]  r_target_line, n_target_line;
    logic        r_irq_enable, n_irq_enable;
    logic        r_in_frame, n_in_frame;
    logic        r_pending, n_pending;
    logic [7:0]  r_line_counter, n_line_counter;
    logic [13:0] r_prev_video_addr, n_prev_video_addr;
    logic [1:0]  r_repeat_count, n_repeat_count;
    logic        r_irq_line, n_irq_line;
    logic [7:0]  r_factor_a, n_factor_a;
    logic [7:0]  r_factor_b, n_factor_b;

    logic [15:0] product;
    logic [15:0] folded;
    logic [13:0] video_addr;
    logic        below_attr;
    logic [1:0]  step_repeat;
    logic        step_en;
    logic [7:0]  read_data;

    scic_mult u_mult (
        .i_factor_a (r_factor_a),
        .i_factor_b (r_factor_b),
        .o_product  (product)
    );

    assign folded     = (i_item.address >= scic_pkg::FOLD_LIMIT)
                        ? (i_item.address & scic_pkg::FOLD_MASK) : i_item.address;
    assign video_addr = folded[13:0];
    assign below_attr = (({2'b00, video_addr} & scic_pkg::FOLD_MASK) < scic_pkg::ATTR_BASE);

    always_comb begin
        n_target_line     = r_target_line;
        n_irq_enable      = r_irq_enable;
        n_in_frame        = r_in_frame;
        n_pending         = r_pending;
        n_line_counter    = r_line_counter;
        n_prev_video_addr = r_prev_video_addr;
        n_repeat_count    = r_repeat_count;
        n_irq_line        = r_irq_line;
        n_factor_a        = r_factor_a;
        n_factor_b        = r_factor_b;
        read_data         = 8'd0;
        step_en           = 1'b0;
        step_repeat       = r_repeat_count;

        unique case (i_item.func)
            scic_pkg::FN_CPU_WRITE: begin
                if (i_item.address[15:13] == scic_pkg::PPU_WIN_HIGH &&
                    i_item.address[2:0] == scic_pkg::PPU_REG_LOW &&
                    (i_item.data & scic_pkg::FRAME_MASK) == 8'd0) begin
                    n_in_frame = 1'b0;
                end
                if (i_item.address == scic_pkg::ADDR_TARGET) begin
                    n_target_line = i_item.data;
                end
                if (i_item.address == scic_pkg::ADDR_STATUS) begin
                    n_irq_enable = i_item.data[7];
                end
                if (i_item.address == scic_pkg::ADDR_PROD_LO) begin
                    n_factor_a = i_item.data;
                end
                if (i_item.address == scic_pkg::ADDR_PROD_HI) begin
                    n_factor_b = i_item.data;
                end
            end
            scic_pkg::FN_CPU_READ: begin
                if (i_item.address == scic_pkg::ADDR_STATUS) begin
                    read_data  = (r_pending ? scic_pkg::STAT_PENDING : 8'd0)
                               | (r_in_frame ? scic_pkg::STAT_IN_FRAME : 8'd0);
                    n_pending  = 1'b0;
                    n_irq_line = 1'b0;
                end else if (i_item.address == scic_pkg::ADDR_PROD_LO) begin
                    read_data = product[7:0];
                end else if (i_item.address == scic_pkg::ADDR_PROD_HI) begin
                    read_data = product[15:8];
                end
            end
            scic_pkg::FN_VID_READ: begin
                if (r_in_frame && below_attr && video_addr == r_prev_video_addr) begin
                    n_repeat_count = (r_repeat_count == scic_pkg::REPEAT_MAX)
                                     ? scic_pkg::REPEAT_MAX : r_repeat_count + 2'd1;
                end else begin
                    n_repeat_count = 2'd0;
                end
                n_prev_video_addr = video_addr;
                step_repeat       = n_repeat_count;
                step_en           = 1'b1;
            end
            scic_pkg::FN_VID_WRITE: begin
                step_en = 1'b1;
            end
            default: begin
                step_en = 1'b0;
            end
        endcase

        // scanline counter step
        if (step_en) begin
            if (r_irq_enable && r_pending) begin
                n_irq_line = 1'b1;
            end
            n_in_frame = i_item.rendering;
            if (!i_item.rendering) begin
                n_line_counter = 8'd0;
            end else if (step_repeat == scic_pkg::REPEAT_FIRST) begin
                if (r_target_line == r_line_counter) begin
                    n_pending = 1'b1;
                end
                n_line_counter = r_line_counter + 8'd1;
            end
        end
    end

    assign o_result.read_data = read_data;
    assign o_result.irq       = n_irq_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_line     <= 8'd0;
            r_irq_enable      <= 1'b0;
            r_in_frame        <= 1'b0;
            r_pending         <= 1'b0;
            r_line_counter    <= 8'd0;
            r_prev_video_addr <= 14'd0;
            r_repeat_count    <= 2'd0;
            r_irq_line        <= 1'b0;
            r_factor_a        <= 8'd0;
            r_factor_b        <= 8'd0;
        end else if (i_step) begin
            r_target_line     <= n_target_line;
            r_irq_enable      <= n_irq_enable;
            r_in_frame        <= n_in_frame;
            r_pending         <= n_pending;
            r_line_counter    <= n_line_counter;
            r_prev_video_addr <= n_prev_video_addr;
            r_repeat_count    <= n_repeat_count;
            r_irq_line        <= n_irq_line;
            r_factor_a        <= n_factor_a;
            r_factor_b        <= n_factor_b;
        end
    end

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.func == scic_pkg::FN_CPU_READ &&
        i_item.address == scic_pkg::ADDR_STATUS |=> !r_pending && !r_irq_line)
        else $error("status read did not clear pending and irq");

    a_irq_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq_line) |-> $past(r_irq_enable) && $past(r_pending))
        else $error("irq rose without enable and pending");

    a_out_of_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_item.rendering &&
        (i_item.func == scic_pkg::FN_VID_READ || i_item.func == scic_pkg::FN_VID_WRITE)
        |=> r_line_counter == 8'd0 && !r_in_frame)
        else $error("line counter not cleared out of frame");

endmodule

### sv/scanline_irq_counter_multiplier_top.sv
// top level: input beat register, mapper state and result register
// Each bus access is one beat: it is registered at the input, evaluated
// against the mapper state by one pass of logic (the 8x8 product is formed
// from the stored factors in that same pass) and lands in the result
// register, so one access per cycle is taken while the result side does not
// stall. The input stalls only while both the input and result registers
// are full and the result side stalls.
module scanline_irq_counter_multiplier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic        i_rendering,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_irq
);

    logic              r_in_valid;
    scic_pkg::t_item   r_item;
    logic              r_out_valid;
    scic_pkg::t_result r_result;
    scic_pkg::t_result result;
    logic              advance;
    logic              accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    scic_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.func      <= scic_pkg::t_func'(i_func);
            r_item.address   <= i_address;
            r_item.data      <= i_data;
            r_item.rendering <= i_rendering;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_result.read_data;
    assign o_irq       = r_result.irq;

endmodule
